@@ hdl/e2r_pkg.sv @@
// Shared constants, types and the arctangent table for the Euler angle to rotation matrix block
package e2r_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int COEF_BITS_DEF  = 16;

  localparam int ITERS = 30;
  localparam int XW    = 33;
  localparam int ZW    = 34;
  localparam int SCW   = 32;
  localparam int PW    = 64;
  localparam int FRAC  = 30;

  localparam logic signed [XW-1:0] GAIN_Q30    = 33'sd652032874;
  localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;

  typedef logic signed [SCW-1:0] trig_val_t;
  typedef logic signed [PW-1:0]  prod_t;

  typedef struct packed {
    logic      vld;
    trig_val_t sr;
    trig_val_t cr;
    trig_val_t sp;
    trig_val_t cp;
    trig_val_t sy;
    trig_val_t cy;
  } trig_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] t;
    case (i)
      0:       t = 34'sd843314856;
      1:       t = 34'sd497837829;
      2:       t = 34'sd263043836;
      3:       t = 34'sd133525158;
      4:       t = 34'sd67021686;
      5:       t = 34'sd33543515;
      6:       t = 34'sd16775850;
      7:       t = 34'sd8388437;
      8:       t = 34'sd4194282;
      9:       t = 34'sd2097149;
      10:      t = 34'sd1048575;
      11:      t = 34'sd524287;
      12:      t = 34'sd262143;
      13:      t = 34'sd131071;
      14:      t = 34'sd65535;
      15:      t = 34'sd32767;
      16:      t = 34'sd16383;
      17:      t = 34'sd8191;
      18:      t = 34'sd4095;
      19:      t = 34'sd2047;
      20:      t = 34'sd1023;
      21:      t = 34'sd511;
      22:      t = 34'sd255;
      23:      t = 34'sd127;
      24:      t = 34'sd63;
      25:      t = 34'sd31;
      26:      t = 34'sd15;
      27:      t = 34'sd7;
      28:      t = 34'sd3;
      29:      t = 34'sd1;
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic prod_t mul_q30(input trig_val_t a, input trig_val_t b);
    prod_t p;
    p = a * b;
    return p;
  endfunction

endpackage

@@ hdl/e2r_if.sv @@
// Stream interfaces for the angle input and the matrix result
interface e2r_angle_if #(
  parameter int ANGLE_BITS = e2r_pkg::ANGLE_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [ANGLE_BITS-1:0] roll;
  logic signed [ANGLE_BITS-1:0] pitch;
  logic signed [ANGLE_BITS-1:0] yaw;

  modport source (output valid, output roll, output pitch, output yaw, input ready);
  modport sink   (input valid, input roll, input pitch, input yaw, output ready);
endinterface

interface e2r_coef_if #(
  parameter int COEF_BITS = e2r_pkg::COEF_BITS_DEF
) ();
  logic                        valid;
  logic                        ready;
  logic signed [COEF_BITS-1:0] r00;
  logic signed [COEF_BITS-1:0] r01;
  logic signed [COEF_BITS-1:0] r02;
  logic signed [COEF_BITS-1:0] r10;
  logic signed [COEF_BITS-1:0] r11;
  logic signed [COEF_BITS-1:0] r12;
  logic signed [COEF_BITS-1:0] r20;
  logic signed [COEF_BITS-1:0] r21;
  logic signed [COEF_BITS-1:0] r22;

  modport source (output valid, output r00, output r01, output r02, output r10, output r11,
                  output r12, output r20, output r21, output r22, input ready);
  modport sink   (input valid, input r00, input r01, input r02, input r10, input r11,
                  input r12, input r20, input r21, input r22, output ready);
endinterface

@@ hdl/e2r_cordic.sv @@
// Pipelined range reduction and rotation CORDIC giving sine and cosine of three angles
module e2r_cordic #(
  parameter int ANGLE_BITS = e2r_pkg::ANGLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic signed [ANGLE_BITS-1:0] ang [0:2],
  output e2r_pkg::trig_t               trig
);

  localparam int N   = e2r_pkg::ITERS;
  localparam int XW  = e2r_pkg::XW;
  localparam int ZW  = e2r_pkg::ZW;
  localparam int SCW = e2r_pkg::SCW;
  localparam int ZSH = 33 - ANGLE_BITS;

  logic [N:0]           v_r;
  logic signed [XW-1:0] x_r [0:N][0:2];
  logic signed [XW-1:0] y_r [0:N][0:2];
  logic signed [ZW-1:0] z_r [0:N][0:2];
  logic                 f_r [0:N][0:2];

  logic signed [ZW-1:0]  z0      [0:2];
  logic signed [ZW-1:0]  zr_nxt  [0:2];
  logic                  fl_nxt  [0:2];
  logic signed [SCW-1:0] s_nxt   [0:2];
  logic signed [SCW-1:0] c_nxt   [0:2];
  e2r_pkg::trig_t        trig_nxt;
  e2r_pkg::trig_t        trig_r;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      z0[l] = ZW'(ang[l]) <<< ZSH;
      if (z0[l] > e2r_pkg::HALF_PI_Q30) begin
        zr_nxt[l] = z0[l] - e2r_pkg::PI_Q30;
        fl_nxt[l] = 1'b1;
      end else if (z0[l] < -e2r_pkg::HALF_PI_Q30) begin
        zr_nxt[l] = z0[l] + e2r_pkg::PI_Q30;
        fl_nxt[l] = 1'b1;
      end else begin
        zr_nxt[l] = z0[l];
        fl_nxt[l] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        x_r[0][l] <= e2r_pkg::GAIN_Q30;
        y_r[0][l] <= '0;
        z_r[0][l] <= zr_nxt[l];
        f_r[0][l] <= fl_nxt[l];
      end
    end
  end

  for (genvar k = 1; k <= N; k++) begin : g_iter
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 3; l++) begin
          f_r[k][l] <= f_r[k-1][l];
          if (!z_r[k-1][l][ZW-1]) begin
            x_r[k][l] <= x_r[k-1][l] - (y_r[k-1][l] >>> (k-1));
            y_r[k][l] <= y_r[k-1][l] + (x_r[k-1][l] >>> (k-1));
            z_r[k][l] <= z_r[k-1][l] - e2r_pkg::atan_q30(k-1);
          end else begin
            x_r[k][l] <= x_r[k-1][l] + (y_r[k-1][l] >>> (k-1));
            y_r[k][l] <= y_r[k-1][l] - (x_r[k-1][l] >>> (k-1));
            z_r[k][l] <= z_r[k-1][l] + e2r_pkg::atan_q30(k-1);
          end
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      s_nxt[l] = SCW'(f_r[N][l] ? -y_r[N][l] : y_r[N][l]);
      c_nxt[l] = SCW'(f_r[N][l] ? -x_r[N][l] : x_r[N][l]);
    end
    trig_nxt.vld = v_r[N];
    trig_nxt.sr  = s_nxt[0];
    trig_nxt.cr  = c_nxt[0];
    trig_nxt.sp  = s_nxt[1];
    trig_nxt.cp  = c_nxt[1];
    trig_nxt.sy  = s_nxt[2];
    trig_nxt.cy  = c_nxt[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_r.vld <= 1'b0;
    end else if (en) begin
      trig_r <= trig_nxt;
    end
  end

  assign trig = trig_r;

endmodule

@@ hdl/e2r_matrix.sv @@
// Multiply pipeline forming the nine matrix entries, with rounding, saturation and output skid
module e2r_matrix #(
  parameter int COEF_BITS = e2r_pkg::COEF_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  e2r_pkg::trig_t      trig,
  output logic                en,
  e2r_coef_if.source          out_chan
);

  localparam int PW   = e2r_pkg::PW;
  localparam int SCW  = e2r_pkg::SCW;
  localparam int FRAC = e2r_pkg::FRAC;
  localparam int SH   = 2 * FRAC - (COEF_BITS - 2);
  localparam logic signed [PW-1:0] Q30_HALF = 64'sd1 <<< (FRAC - 1);
  localparam logic signed [PW-1:0] R_HALF   = 64'sd1 <<< (SH - 1);
  localparam logic signed [PW-1:0] LIM      = 64'sd1 <<< (COEF_BITS - 2);

  // stage 1: first products
  logic               m1_v_r;
  e2r_pkg::prod_t     p_spsr_r, p_spcr_r, q00_1_r, q10_1_r, q21_1_r, q22_1_r;
  e2r_pkg::trig_val_t cy1_r, sy1_r, sr1_r, cr1_r, sp1_r;
  // stage 2: round the pitch-roll products
  logic               m2_v_r;
  e2r_pkg::trig_val_t spsr2_r, spcr2_r, cy2_r, sy2_r, sr2_r, cr2_r, sp2_r;
  e2r_pkg::prod_t     q00_2_r, q10_2_r, q21_2_r, q22_2_r;
  // stage 3: second products
  logic               m3_v_r;
  e2r_pkg::prod_t     t_r [0:7];
  e2r_pkg::prod_t     q00_3_r, q10_3_r, q21_3_r, q22_3_r;
  e2r_pkg::trig_val_t sp3_r;
  // stage 4: sums
  logic               m4_v_r;
  e2r_pkg::prod_t     sum_r [0:8];
  e2r_pkg::prod_t     sp_q60;

  e2r_pkg::prod_t              rnd     [0:8];
  logic signed [COEF_BITS-1:0] coef_nxt [0:8];

  logic                        o_v_r, sk_v_r;
  logic signed [COEF_BITS-1:0] o_d_r  [0:8];
  logic signed [COEF_BITS-1:0] sk_d_r [0:8];
  logic                        push, take;

  assign en = !sk_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
      m3_v_r <= 1'b0;
      m4_v_r <= 1'b0;
    end else if (en) begin
      m1_v_r <= trig.vld;
      m2_v_r <= m1_v_r;
      m3_v_r <= m2_v_r;
      m4_v_r <= m3_v_r;
    end
  end

  assign sp_q60 = PW'(sp3_r) <<< FRAC;

  always_ff @(posedge clk) begin
    if (en) begin
      p_spsr_r <= e2r_pkg::mul_q30(trig.sp, trig.sr);
      p_spcr_r <= e2r_pkg::mul_q30(trig.sp, trig.cr);
      q00_1_r  <= e2r_pkg::mul_q30(trig.cy, trig.cp);
      q10_1_r  <= e2r_pkg::mul_q30(trig.sy, trig.cp);
      q21_1_r  <= e2r_pkg::mul_q30(trig.cp, trig.sr);
      q22_1_r  <= e2r_pkg::mul_q30(trig.cp, trig.cr);
      cy1_r    <= trig.cy;
      sy1_r    <= trig.sy;
      sr1_r    <= trig.sr;
      cr1_r    <= trig.cr;
      sp1_r    <= trig.sp;

      spsr2_r  <= SCW'((p_spsr_r + Q30_HALF) >>> FRAC);
      spcr2_r  <= SCW'((p_spcr_r + Q30_HALF) >>> FRAC);
      cy2_r    <= cy1_r;
      sy2_r    <= sy1_r;
      sr2_r    <= sr1_r;
      cr2_r    <= cr1_r;
      sp2_r    <= sp1_r;
      q00_2_r  <= q00_1_r;
      q10_2_r  <= q10_1_r;
      q21_2_r  <= q21_1_r;
      q22_2_r  <= q22_1_r;

      t_r[0]   <= e2r_pkg::mul_q30(cy2_r, spsr2_r);
      t_r[1]   <= e2r_pkg::mul_q30(sy2_r, cr2_r);
      t_r[2]   <= e2r_pkg::mul_q30(cy2_r, spcr2_r);
      t_r[3]   <= e2r_pkg::mul_q30(sy2_r, sr2_r);
      t_r[4]   <= e2r_pkg::mul_q30(sy2_r, spsr2_r);
      t_r[5]   <= e2r_pkg::mul_q30(cy2_r, cr2_r);
      t_r[6]   <= e2r_pkg::mul_q30(sy2_r, spcr2_r);
      t_r[7]   <= e2r_pkg::mul_q30(cy2_r, sr2_r);
      q00_3_r  <= q00_2_r;
      q10_3_r  <= q10_2_r;
      q21_3_r  <= q21_2_r;
      q22_3_r  <= q22_2_r;
      sp3_r    <= sp2_r;

      sum_r[0] <= q00_3_r;
      sum_r[1] <= t_r[0] - t_r[1];
      sum_r[2] <= t_r[2] + t_r[3];
      sum_r[3] <= q10_3_r;
      sum_r[4] <= t_r[4] + t_r[5];
      sum_r[5] <= t_r[6] - t_r[7];
      sum_r[6] <= -sp_q60;
      sum_r[7] <= q21_3_r;
      sum_r[8] <= q22_3_r;
    end
  end

  always_comb begin
    for (int j = 0; j < 9; j++) begin
      rnd[j] = (sum_r[j] + R_HALF) >>> SH;
      if (rnd[j] > LIM) begin
        coef_nxt[j] = COEF_BITS'(LIM);
      end else if (rnd[j] < -LIM) begin
        coef_nxt[j] = COEF_BITS'(-LIM);
      end else begin
        coef_nxt[j] = COEF_BITS'(rnd[j]);
      end
    end
  end

  assign push = m4_v_r && en;
  assign take = o_v_r && out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r  <= 1'b0;
      sk_v_r <= 1'b0;
    end else if (sk_v_r) begin
      if (take) begin
        o_d_r  <= sk_d_r;
        sk_v_r <= 1'b0;
      end
    end else if (push) begin
      if (!o_v_r || take) begin
        o_d_r <= coef_nxt;
        o_v_r <= 1'b1;
      end else begin
        sk_d_r <= coef_nxt;
        sk_v_r <= 1'b1;
      end
    end else if (take) begin
      o_v_r <= 1'b0;
    end
  end

  assign out_chan.valid = o_v_r;
  assign out_chan.r00   = o_d_r[0];
  assign out_chan.r01   = o_d_r[1];
  assign out_chan.r02   = o_d_r[2];
  assign out_chan.r10   = o_d_r[3];
  assign out_chan.r11   = o_d_r[4];
  assign out_chan.r12   = o_d_r[5];
  assign out_chan.r20   = o_d_r[6];
  assign out_chan.r21   = o_d_r[7];
  assign out_chan.r22   = o_d_r[8];

endmodule

@@ hdl/euler_to_rotation_matrix.sv @@
// Top level: roll, pitch and yaw to the ZYX rotation matrix
//
//   channel   dir   handshake      payload
//   in_chan   in    valid/ready    roll, pitch, yaw
//   out_chan  out   valid/ready    r00 .. r22
//
// One item per cycle while ready is high; the pipe holds range reduction, 30 CORDIC stages,
// sine/cosine output, four multiply/sum stages and the output register.
// Synchronous active-low reset clears the valid bits only.
// The whole pipe advances together; a one-item skid behind the output register absorbs a
// stall, and ready drops only once the skid holds an item.
module euler_to_rotation_matrix #(
  parameter int ANGLE_BITS = e2r_pkg::ANGLE_BITS_DEF,
  parameter int COEF_BITS  = e2r_pkg::COEF_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  e2r_angle_if.sink   in_chan,
  e2r_coef_if.source  out_chan
);

  localparam logic signed [COEF_BITS-1:0] ONE = COEF_BITS'(1) <<< (COEF_BITS - 2);

  logic                         en;
  logic signed [ANGLE_BITS-1:0] ang [0:2];
  e2r_pkg::trig_t               trig;

  assign ang[0]        = in_chan.roll;
  assign ang[1]        = in_chan.pitch;
  assign ang[2]        = in_chan.yaw;
  assign in_chan.ready = en;

  e2r_cordic #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_chan.valid),
    .ang      (ang),
    .trig     (trig)
  );

  e2r_matrix #(
    .COEF_BITS (COEF_BITS)
  ) u_matrix (
    .clk      (clk),
    .rst_n    (rst_n),
    .trig     (trig),
    .en       (en),
    .out_chan (out_chan)
  );

  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> out_chan.valid)
    else $error("input stalled with no result on the output");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_chan.ready && !out_chan.ready) |=> !in_chan.ready)
    else $error("input stall released while the output stayed blocked");

  a_r20_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.r20 <= ONE && out_chan.r20 >= -ONE))
    else $error("matrix entry beyond plus or minus one");

  a_r00_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.r00 <= ONE && out_chan.r00 >= -ONE))
    else $error("matrix entry beyond plus or minus one");

endmodule
